// ===== design/dwep_pkg.sv =====
// Shared types, constants and helper functions of the two-wheel position drive.
`default_nettype none
package dwep_pkg;

   localparam int DIST_W  = 24;
   localparam int POS_W   = DIST_W + 1;
   localparam int ERR_W   = DIST_W + 2;
   localparam int HALF_W  = ERR_W - 1;
   localparam int TICK_W  = 32;
   localparam int PWM_W   = 8;
   localparam int ACT_W   = 2;
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [ACT_W-1:0] ACT_EDGE    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_TIMEOUT = 2'd1;
   localparam logic [ACT_W-1:0] ACT_START   = 2'd2;

   localparam logic [PWM_W-1:0]  PWM_MAX        = 8'd255;
   localparam logic [PWM_W-1:0]  MIN_PWM_RESET  = 8'd20;
   localparam logic [TICK_W-1:0] INTERVAL_RESET = 32'd100000;

   // One classified request as it travels from the front to the back.
   typedef struct packed {
      logic              is_edge;
      logic              is_timeout;
      logic              is_start;
      logic              wheel;
      logic [TICK_W-1:0] tick;
      logic [DIST_W-1:0] left_goal;
      logic [DIST_W-1:0] right_goal;
      logic              left_bw;
      logic              right_bw;
   } cmd_type;

   typedef struct packed {
      logic [PWM_W-1:0] left_duty;
      logic [PWM_W-1:0] right_duty;
      logic             left_backward;
      logic             right_backward;
      logic             arrived;
      logic             speed_updated;
   } rsp_type;

   typedef struct packed {
      logic             drive_bw;
      logic [PWM_W-1:0] pwm;
   } steer_type;

   function automatic logic [PWM_W-1:0] inc_sat(logic [PWM_W-1:0] v);
      return (v < PWM_MAX) ? v + 1'b1 : v;
   endfunction

   function automatic logic [PWM_W-1:0] dec_sat(logic [PWM_W-1:0] v);
      return (v != '0) ? v - 1'b1 : v;
   endfunction

   // Reverse on overshoot, then step the duty one unit toward the clamped half error.
   function automatic steer_type steer(logic [ERR_W-1:0] err, logic goal_bw,
                                       logic [PWM_W-1:0] pwm, logic [PWM_W-1:0] min_pwm);
      logic [ERR_W-1:0]  mag;
      logic [HALF_W-1:0] half;
      logic [PWM_W-1:0]  target;
      steer_type         r;
      r.drive_bw = err[ERR_W-1] ? !goal_bw : goal_bw;
      mag        = err[ERR_W-1] ? (~err + 1'b1) : err;
      half       = mag[ERR_W-1:1];
      if (half > HALF_W'(PWM_MAX)) begin
         target = PWM_MAX;
      end else begin
         target = half[PWM_W-1:0];
      end
      if (target < min_pwm) begin
         target = min_pwm;
      end
      r.pwm = (pwm < target) ? inc_sat(pwm) : dec_sat(pwm);
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== design/dwep_front.sv =====
// Front end: decode the request action and turn start distances into goals.
`default_nettype none
module dwep_front import dwep_pkg::*; (
   input  wire logic [ACT_W-1:0]  req_action,
   input  wire logic              req_wheel,
   input  wire logic [TICK_W-1:0] req_tick,
   input  wire logic [DIST_W-1:0] req_left_distance,
   input  wire logic [DIST_W-1:0] req_right_distance,
   output cmd_type                cmd
);

   always_comb begin
      cmd            = '0;
      cmd.wheel      = req_wheel;
      cmd.tick       = req_tick;
      cmd.left_bw    = req_left_distance[DIST_W-1];
      cmd.right_bw   = req_right_distance[DIST_W-1];
      // magnitude of the signed distance; the most negative value still fits unsigned
      cmd.left_goal  = cmd.left_bw ? (~req_left_distance + 1'b1) : req_left_distance;
      cmd.right_goal = cmd.right_bw ? (~req_right_distance + 1'b1) : req_right_distance;
      case (req_action)
         ACT_EDGE:    cmd.is_edge    = 1'b1;
         ACT_TIMEOUT: cmd.is_timeout = 1'b1;
         ACT_START:   cmd.is_start   = 1'b1;
         default: begin
            // unused action: passes through as a plain status report
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== design/dwep_queue.sv =====
// Short request queue between the front end and the execution back end.
`default_nettype none
module dwep_queue import dwep_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire cmd_type push_cmd,
   output logic         full,
   output logic         pop_valid,
   output cmd_type      pop_cmd,
   input  wire logic    pop_take
);

   cmd_type              mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 push, pop;

   assign full      = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = mem_ff[rd_ptr_ff];
   assign push      = push_valid && !full;
   assign pop       = pop_valid && pop_take;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ===== design/dwep_back.sv =====
// Back end: wheel state, timed speed update, watchdog handling and result register.
`default_nettype none
module dwep_back import dwep_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   input  wire logic [TICK_W-1:0] csr_data,
   input  wire logic              cmd_valid,
   input  wire cmd_type           cmd,
   output logic                   cmd_take,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output rsp_type                rsp
);

   logic [TICK_W-1:0] interval_ff;
   logic [DIST_W-1:0] left_goal_ff, left_goal_in, right_goal_ff, right_goal_in;
   logic [POS_W-1:0]  left_pos_ff, left_pos_in, right_pos_ff, right_pos_in;
   logic [PWM_W-1:0]  left_pwm_ff, left_pwm_in, right_pwm_ff, right_pwm_in;
   logic              left_gbw_ff, left_gbw_in, right_gbw_ff, right_gbw_in;
   logic              left_dbw_ff, left_dbw_in, right_dbw_ff, right_dbw_in;
   logic [TICK_W-1:0] last_ff, last_in;
   logic [PWM_W-1:0]  min_pwm_ff, min_pwm_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;

   logic              fire, due;
   logic [TICK_W-1:0] elapsed;
   logic [POS_W-1:0]  left_step, right_step;
   logic [ERR_W-1:0]  left_err, right_err, sel_err;
   logic              both_zero;
   steer_type         left_steer, right_steer;

   assign fire      = cmd_valid && (!rsp_valid_ff || !rsp_stall);
   assign cmd_take  = fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign elapsed    = cmd.tick - last_ff;
   assign due        = cmd.is_edge && (elapsed >= interval_ff);
   assign left_step  = (left_dbw_ff == left_gbw_ff) ? POS_W'(1) : '1;
   assign right_step = (right_dbw_ff == right_gbw_ff) ? POS_W'(1) : '1;

   always_comb begin
      left_pos_in  = left_pos_ff;
      right_pos_in = right_pos_ff;
      if (cmd.is_edge && !cmd.wheel) begin
         left_pos_in = left_pos_ff + left_step;
      end
      if (cmd.is_edge && cmd.wheel) begin
         right_pos_in = right_pos_ff + right_step;
      end
   end

   // error against the sign-extended count, taken after this edge's count step
   assign left_err    = {2'b00, left_goal_ff} - {left_pos_in[POS_W-1], left_pos_in};
   assign right_err   = {2'b00, right_goal_ff} - {right_pos_in[POS_W-1], right_pos_in};
   assign both_zero   = (left_err == '0) && (right_err == '0);
   assign sel_err     = cmd.wheel ? right_err : left_err;
   assign left_steer  = steer(left_err, left_gbw_ff, left_pwm_ff, min_pwm_ff);
   assign right_steer = steer(right_err, right_gbw_ff, right_pwm_ff, min_pwm_ff);

   always_comb begin
      left_goal_in      = left_goal_ff;
      right_goal_in     = right_goal_ff;
      left_gbw_in       = left_gbw_ff;
      right_gbw_in      = right_gbw_ff;
      left_dbw_in       = left_dbw_ff;
      right_dbw_in      = right_dbw_ff;
      left_pwm_in       = left_pwm_ff;
      right_pwm_in      = right_pwm_ff;
      last_in           = last_ff;
      min_pwm_in        = min_pwm_ff;
      rsp_in.arrived       = 1'b0;
      rsp_in.speed_updated = 1'b0;
      if (cmd.is_start) begin
         left_goal_in  = cmd.left_goal;
         right_goal_in = cmd.right_goal;
         left_gbw_in   = cmd.left_bw;
         right_gbw_in  = cmd.right_bw;
         left_dbw_in   = cmd.left_bw;
         right_dbw_in  = cmd.right_bw;
         left_pwm_in   = min_pwm_ff;
         right_pwm_in  = min_pwm_ff;
         last_in       = '1;
      end else if (cmd.is_timeout) begin
         if (both_zero) begin
            rsp_in.arrived = 1'b1;
         end else begin
            min_pwm_in = inc_sat(min_pwm_ff);
            if (!sel_err[ERR_W-1] && sel_err != '0) begin
               if (cmd.wheel) right_pwm_in = inc_sat(right_pwm_ff);
               else           left_pwm_in  = inc_sat(left_pwm_ff);
            end else if (sel_err[ERR_W-1]) begin
               if (cmd.wheel) right_pwm_in = dec_sat(right_pwm_ff);
               else           left_pwm_in  = dec_sat(left_pwm_ff);
            end
         end
      end else if (due) begin
         rsp_in.speed_updated = 1'b1;
         last_in              = cmd.tick;
         if (both_zero) begin
            rsp_in.arrived = 1'b1;
         end else begin
            if (left_err != '0) begin
               left_dbw_in = left_steer.drive_bw;
               left_pwm_in = left_steer.pwm;
            end
            if (right_err != '0) begin
               right_dbw_in = right_steer.drive_bw;
               right_pwm_in = right_steer.pwm;
            end
         end
      end
      rsp_in.left_duty      = left_pwm_in;
      rsp_in.right_duty     = right_pwm_in;
      rsp_in.left_backward  = left_dbw_in;
      rsp_in.right_backward = right_dbw_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
      end else if (csr_valid) begin
         interval_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_goal_ff  <= '0;
         right_goal_ff <= '0;
         left_pos_ff   <= '0;
         right_pos_ff  <= '0;
         left_pwm_ff   <= '0;
         right_pwm_ff  <= '0;
         left_gbw_ff   <= 1'b0;
         right_gbw_ff  <= 1'b0;
         left_dbw_ff   <= 1'b0;
         right_dbw_ff  <= 1'b0;
         last_ff       <= '1;
         min_pwm_ff    <= MIN_PWM_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (fire) begin
            left_goal_ff  <= left_goal_in;
            right_goal_ff <= right_goal_in;
            left_pos_ff   <= cmd.is_start ? '0 : left_pos_in;
            right_pos_ff  <= cmd.is_start ? '0 : right_pos_in;
            left_pwm_ff   <= left_pwm_in;
            right_pwm_ff  <= right_pwm_in;
            left_gbw_ff   <= left_gbw_in;
            right_gbw_ff  <= right_gbw_in;
            left_dbw_ff   <= left_dbw_in;
            right_dbw_ff  <= right_dbw_in;
            last_ff       <= last_in;
            min_pwm_ff    <= min_pwm_in;
            rsp_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      fire && cmd.is_start |=> left_pos_ff == '0 && right_pos_ff == '0
                               && last_ff == '1)
      else $error("start did not clear positions and update time");
   a_update_time: assert property (@(posedge clock) disable iff (reset)
      fire && due && !cmd.is_start && !cmd.is_timeout |=> last_ff == $past(cmd.tick))
      else $error("timed update did not record its tick");
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff && rsp_ff.left_duty == left_pwm_ff
               && rsp_ff.right_duty == right_pwm_ff)
      else $error("result does not reflect the executed request");
`endif

endmodule
`default_nettype wire

// ===== design/dual_wheel_encoder_position_drive.sv =====
// Top level of the two-wheel encoder position drive.
`default_nettype none
// Two-wheel encoder position drive. Each request is a start move (loads signed
// distances per wheel, clears the counts, sets both duties to the minimum), a
// falling encoder edge (counts that wheel and, once check_interval microseconds
// have passed since the last timed update, runs the speed update), or a watchdog
// timeout (reports arrival or raises the minimum duty and nudges one wheel).
// Every request yields exactly one response with both duties, both drive
// directions and the arrived / speed_updated pulses. A request is accepted on
// req_valid with req_stall low and a response is taken on rsp_valid with
// rsp_stall low. The front end decodes requests into a two-entry queue; the
// back end executes one request per cycle into a response register, unless a
// waiting response is stalled, so the sustained rate is one request per clock.
// The queue holds up to two requests while a response waits. check_interval
// is written through csr_valid/csr_data (csr_ready is always high); the user
// must write it only while the block is idle, which the block does not enforce.
module dual_wheel_encoder_position_drive import dwep_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [ACT_W-1:0]         req_action,
   input  wire logic                     req_wheel,
   input  wire logic [TICK_W-1:0]        req_tick,
   input  wire logic signed [DIST_W-1:0] req_left_distance,
   input  wire logic signed [DIST_W-1:0] req_right_distance,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [PWM_W-1:0]              rsp_left_duty,
   output logic [PWM_W-1:0]              rsp_right_duty,
   output logic                          rsp_left_backward,
   output logic                          rsp_right_backward,
   output logic                          rsp_arrived,
   output logic                          rsp_speed_updated,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [TICK_W-1:0]        csr_data
);

   cmd_type front_cmd;
   cmd_type queue_cmd;
   logic    queue_valid;
   logic    queue_take;
   rsp_type rsp;

   // the register write is always taken
   assign csr_ready = 1'b1;

   // decode the request and form the start goals
   dwep_front u_front (
      .req_action         (req_action),
      .req_wheel          (req_wheel),
      .req_tick           (req_tick),
      .req_left_distance  (req_left_distance),
      .req_right_distance (req_right_distance),
      .cmd                (front_cmd)
   );

   // hold decoded requests; stall the requester only while the queue is full
   dwep_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_cmd   (front_cmd),
      .full       (req_stall),
      .pop_valid  (queue_valid),
      .pop_cmd    (queue_cmd),
      .pop_take   (queue_take)
   );

   // execute against the wheel state and register the response
   dwep_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd_valid (queue_valid),
      .cmd       (queue_cmd),
      .cmd_take  (queue_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_left_duty      = rsp.left_duty;
   assign rsp_right_duty     = rsp.right_duty;
   assign rsp_left_backward  = rsp.left_backward;
   assign rsp_right_backward = rsp.right_backward;
   assign rsp_arrived        = rsp.arrived;
   assign rsp_speed_updated  = rsp.speed_updated;

endmodule
`default_nettype wire
